// File: rtl/atm_pkg.sv
// package for the alarm timer table: sizes, codes and slot record
`default_nettype none

package atm_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {
        OP_ACT    = 2'd0,
        OP_DEACT  = 2'd1,
        OP_TICK   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ACT_OK  = 3'd0,
        KIND_ACT_REJ = 3'd1,
        KIND_DEACT   = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_NOEXP   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic        periodic;
        logic [23:0] delay;
        logic [31:0] start;
        logic [7:0]  event_id;
        logic [31:0] aux;
    } slot_t;

endpackage

`default_nettype wire

// File: rtl/alarm_timer_table_core.sv
// alarm timer table: slot memory, sequential slot scan and result register
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   op, now_ms, event_id, aux_data, alarm_word
// out       output     out_valid / out_stall kind, fired_event_id, fired_aux_data, last
//
// every activate, deactivate or tick transaction walks the slot memory one entry a cycle,
// unless a tick holds on a fire; the pace is set by the single read port of the slot memory
// a fire found during a tick waits in a holding register until the next fire or the scan end
// out_stall holds the scan only when a result must move and the output register is still full
// reset clears the active bits; slot memory contents need no clearing
// op code 3 is dropped on acceptance and produces no transaction on out
`default_nettype none

module alarm_timer_table_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] now_ms,
    input  wire logic [7:0]  event_id,
    input  wire logic [31:0] aux_data,
    input  wire logic [31:0] alarm_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [7:0]       fired_event_id,
    output logic [31:0]      fired_aux_data,
    output logic             last
);

    localparam int IW = atm_pkg::SLOT_IDX_W;
    localparam int NS = atm_pkg::NUM_SLOTS;

    atm_pkg::state_t state_reg, state_next;
    atm_pkg::op_t    op_reg;
    logic [31:0]     now_reg;
    logic [7:0]      ev_reg;
    logic [31:0]     aux_reg;
    logic            periodic_reg;
    logic [23:0]     delay_reg;
    logic [IW-1:0]   idx_reg;
    logic            found_reg;
    logic [IW-1:0]   match_reg;
    logic            pend_valid_reg;
    logic [7:0]      pend_ev_reg;
    logic [31:0]     pend_aux_reg;
    logic [NS-1:0]   active_reg;

    logic            out_valid_reg;
    atm_pkg::kind_t  kind_reg;
    logic [7:0]      out_ev_reg;
    logic [31:0]     out_aux_reg;
    logic            last_reg;

    atm_pkg::slot_t  mem [NS];
    atm_pkg::slot_t  rd_data_reg;

    logic            accept;
    logic            can_push;
    logic            scan_end;
    logic            fire;
    logic            hit;
    logic [31:0]     elapsed;
    logic            free_found;
    logic [IW-1:0]   free_idx;
    logic [IW-1:0]   target;
    logic            act_ok;

    logic            advance;
    logic            mem_re;
    logic [IW-1:0]   rd_addr;
    logic            mem_we;
    logic [IW-1:0]   wr_addr;
    atm_pkg::slot_t  wr_data;
    logic            push;
    atm_pkg::kind_t  push_kind;
    logic [7:0]      push_ev;
    logic [31:0]     push_aux;
    logic            push_last;
    logic            pend_load;
    logic            pend_clear;
    logic            act_set;
    logic            act_clr;
    logic [IW-1:0]   act_idx;
    logic            found_set;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != atm_pkg::ST_IDLE);
    assign can_push = !out_valid_reg || !out_stall;
    assign scan_end = (idx_reg == IW'(NS - 1));
    assign elapsed  = now_reg - rd_data_reg.start;
    assign fire     = active_reg[idx_reg] && (elapsed >= {8'd0, rd_data_reg.delay});
    assign hit      = active_reg[idx_reg] && (rd_data_reg.event_id == ev_reg)
                      && (rd_data_reg.aux == aux_reg);
    assign target   = found_reg ? match_reg : free_idx;
    assign act_ok   = (found_reg || free_found) && (delay_reg != 24'd0);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < NS; i++)
        begin
            if (!active_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            atm_pkg::ST_IDLE:
            begin
                if (accept && (op != atm_pkg::OP_UNUSED))
                    state_next = atm_pkg::ST_SCAN;
            end
            atm_pkg::ST_SCAN:
            begin
                if (advance && scan_end)
                    state_next = (op_reg == atm_pkg::OP_TICK) ? atm_pkg::ST_FLUSH
                                                              : atm_pkg::ST_DONE;
            end
            atm_pkg::ST_DONE,
            atm_pkg::ST_FLUSH:
            begin
                if (can_push)
                    state_next = atm_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        advance    = 1'b0;
        mem_re     = 1'b0;
        rd_addr    = '0;
        mem_we     = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data_reg;
        push       = 1'b0;
        push_kind  = atm_pkg::KIND_NOEXP;
        push_ev    = 8'd0;
        push_aux   = 32'd0;
        push_last  = 1'b1;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        act_set    = 1'b0;
        act_clr    = 1'b0;
        act_idx    = idx_reg;
        found_set  = 1'b0;
        unique case (state_reg)
            atm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mem_re  = 1'b1;
                    rd_addr = '0;
                end
            end
            atm_pkg::ST_SCAN:
            begin
                if (op_reg == atm_pkg::OP_TICK)
                begin
                    advance = !fire || !pend_valid_reg || can_push;
                    if (fire && advance)
                    begin
                        pend_load = 1'b1;
                        if (pend_valid_reg)
                        begin
                            push      = 1'b1;
                            push_kind = atm_pkg::KIND_FIRED;
                            push_ev   = pend_ev_reg;
                            push_aux  = pend_aux_reg;
                            push_last = 1'b0;
                        end
                        if (rd_data_reg.periodic)
                        begin
                            mem_we        = 1'b1;
                            wr_data.start = now_reg;
                        end
                        else
                        begin
                            act_clr = 1'b1;
                        end
                    end
                end
                else
                begin
                    advance   = 1'b1;
                    found_set = hit && !found_reg;
                end
                if (advance && !scan_end)
                begin
                    mem_re  = 1'b1;
                    rd_addr = idx_reg + 1'b1;
                end
            end
            atm_pkg::ST_DONE:
            begin
                if (can_push)
                begin
                    push   = 1'b1;
                    if (op_reg == atm_pkg::OP_ACT)
                    begin
                        push_kind = act_ok ? atm_pkg::KIND_ACT_OK : atm_pkg::KIND_ACT_REJ;
                        if (act_ok)
                        begin
                            mem_we           = 1'b1;
                            wr_addr          = target;
                            wr_data.periodic = periodic_reg;
                            wr_data.delay    = delay_reg;
                            wr_data.start    = now_reg;
                            wr_data.event_id = ev_reg;
                            wr_data.aux      = aux_reg;
                            act_set          = 1'b1;
                            act_idx          = target;
                        end
                    end
                    else
                    begin
                        push_kind = atm_pkg::KIND_DEACT;
                        act_clr   = found_reg;
                        act_idx   = match_reg;
                    end
                end
            end
            atm_pkg::ST_FLUSH:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    pend_clear = 1'b1;
                    if (pend_valid_reg)
                    begin
                        push_kind = atm_pkg::KIND_FIRED;
                        push_ev   = pend_ev_reg;
                        push_aux  = pend_aux_reg;
                    end
                end
            end
        endcase
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= atm_pkg::ST_IDLE;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (act_set)
                active_reg[act_idx] <= 1'b1;
            else if (act_clr)
                active_reg[act_idx] <= 1'b0;
            if (pend_load)
                pend_valid_reg <= 1'b1;
            else if (pend_clear)
                pend_valid_reg <= 1'b0;
            if (push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                found_reg <= 1'b0;
                idx_reg   <= '0;
            end
            else
            begin
                if (found_set)
                    found_reg <= 1'b1;
                if (advance && !scan_end)
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= atm_pkg::op_t'(op);
            now_reg      <= now_ms;
            ev_reg       <= event_id;
            aux_reg      <= aux_data;
            periodic_reg <= alarm_word[0];
            delay_reg    <= alarm_word[31:8];
        end
        if (found_set)
            match_reg <= idx_reg;
        if (pend_load)
        begin
            pend_ev_reg  <= rd_data_reg.event_id;
            pend_aux_reg <= rd_data_reg.aux;
        end
        if (push)
        begin
            kind_reg    <= push_kind;
            out_ev_reg  <= push_ev;
            out_aux_reg <= push_aux;
            last_reg    <= push_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign fired_event_id = out_ev_reg;
    assign fired_aux_data = out_aux_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// File: rtl/atm_checker.sv
// port-level checks for the alarm timer table and their bind
`default_nettype none

module atm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  op,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  kind,
    input wire logic [7:0]  fired_event_id,
    input wire logic [31:0] fired_aux_data,
    input wire logic        last
);

    // stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last)
            && $stable(fired_event_id) && $stable(fired_aux_data))
    else $error("stalled result changed");

    // accepted work holds off the next transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op != atm_pkg::OP_UNUSED) |=> in_stall)
    else $error("input taken during a scan");

    // only fired results carry alarm identity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != atm_pkg::KIND_FIRED) |-> (fired_event_id == 8'd0)
            && (fired_aux_data == 32'd0))
    else $error("identity on a non-fire result");

    // single-result kinds always close their transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((kind == atm_pkg::KIND_ACT_OK) || (kind == atm_pkg::KIND_ACT_REJ)
            || (kind == atm_pkg::KIND_DEACT) || (kind == atm_pkg::KIND_NOEXP)) |-> last)
    else $error("single result without last");

endmodule

bind alarm_timer_table_core atm_checker u_atm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .fired_event_id (fired_event_id),
    .fired_aux_data (fired_aux_data),
    .last           (last)
);

`default_nettype wire
